[rtl/smpd_pkg.sv]
// ----------------------------------------------------------------------------
// smpd_pkg
// types and constants shared by the serial mouse packet decoder
// ----------------------------------------------------------------------------
package smpd_pkg;

    localparam int RX_W      = 8;
    localparam int DATA_W    = 7;
    localparam int DELTA_W   = 8;
    localparam int BTN_W     = 3;
    localparam int TDATA_W   = 32;

    localparam int START_BIT  = 6;
    localparam int MIDDLE_BIT = 5;

    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_MIDDLE = 2;

    // byte position inside the packet
    typedef enum logic [3:0] {
        POS_BYTE0 = 4'b0001,
        POS_BYTE1 = 4'b0010,
        POS_BYTE2 = 4'b0100,
        POS_EXTRA = 4'b1000
    } pos_t;

    // first member lands in the highest bits of the packed word
    typedef struct packed {
        logic                       middle_went_up;
        logic                       middle_went_down;
        logic                       right_went_up;
        logic                       right_went_down;
        logic                       left_went_up;
        logic                       left_went_down;
        logic                       middle_pressed;
        logic                       right_pressed;
        logic                       left_pressed;
        logic signed [DELTA_W-1:0]  delta_y;
        logic signed [DELTA_W-1:0]  delta_x;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int PAD_W    = TDATA_W - RESULT_W;

    typedef struct packed {
        logic               emit;
        logic               wr_byte0;
        logic               wr_byte1;
        pos_t               pos_next;
        logic [BTN_W-1:0]   buttons_next;
        result_t            result;
    } decode_t;

endpackage

[rtl/smpd_decode.sv]
// ----------------------------------------------------------------------------
// smpd_decode
// decodes one received byte against the held packet state
// ----------------------------------------------------------------------------
module smpd_decode (
    input  logic [smpd_pkg::RX_W-1:0]    rx_byte,
    input  smpd_pkg::pos_t               pos,
    input  logic [smpd_pkg::DATA_W-1:0]  byte0,
    input  logic [smpd_pkg::DATA_W-1:0]  byte1,
    input  logic [smpd_pkg::BTN_W-1:0]   buttons,
    output smpd_pkg::decode_t            dec
);
    import smpd_pkg::*;

    logic [DATA_W-1:0]  data;
    pos_t               pos_eff;
    logic [BTN_W-1:0]   now;
    logic [BTN_W-1:0]   diff;
    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;

    assign data    = rx_byte[DATA_W-1:0];
    assign pos_eff = rx_byte[START_BIT] ? POS_BYTE0 : pos;

    always_comb
    begin
        dec.emit     = 1'b0;
        dec.wr_byte0 = 1'b0;
        dec.wr_byte1 = 1'b0;
        dec.pos_next = POS_BYTE0;
        now          = buttons;
        dx           = '0;
        dy           = '0;
        unique case (pos_eff)
            POS_BYTE0:
            begin
                dec.wr_byte0 = 1'b1;
                dec.pos_next = POS_BYTE1;
            end
            POS_BYTE1:
            begin
                dec.wr_byte1 = 1'b1;
                dec.pos_next = POS_BYTE2;
            end
            POS_BYTE2:
            begin
                dec.emit     = 1'b1;
                dec.pos_next = POS_EXTRA;
                dx  = {1'b0, byte1} | {byte0[1:0], 6'b0};
                dy  = {1'b0, data}  | {byte0[3:2], 6'b0};
                now = {buttons[BTN_MIDDLE], byte0[4], byte0[5]};
            end
            default:
            begin
                // optional extra byte carries the middle button
                dec.pos_next = POS_BYTE0;
                dec.emit     = data[MIDDLE_BIT] != buttons[BTN_MIDDLE];
                now          = buttons ^ (BTN_W'(1) << BTN_MIDDLE);
            end
        endcase

        diff             = buttons ^ now;
        dec.buttons_next = dec.emit ? now : buttons;

        dec.result.delta_x          = dx;
        dec.result.delta_y          = dy;
        dec.result.left_pressed     = now[BTN_LEFT];
        dec.result.right_pressed    = now[BTN_RIGHT];
        dec.result.middle_pressed   = now[BTN_MIDDLE];
        dec.result.left_went_down   = diff[BTN_LEFT]   &  now[BTN_LEFT];
        dec.result.left_went_up     = diff[BTN_LEFT]   & ~now[BTN_LEFT];
        dec.result.right_went_down  = diff[BTN_RIGHT]  &  now[BTN_RIGHT];
        dec.result.right_went_up    = diff[BTN_RIGHT]  & ~now[BTN_RIGHT];
        dec.result.middle_went_down = diff[BTN_MIDDLE] &  now[BTN_MIDDLE];
        dec.result.middle_went_up   = diff[BTN_MIDDLE] & ~now[BTN_MIDDLE];
    end

endmodule

[rtl/serial_mouse_packet_decoder.sv]
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder
// three-button serial mouse packet decoder, one received byte per word
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while s_tready is high, and gives a
// motion and button event on the third byte of a packet and another on an
// optional fourth byte when it toggles the middle button. A byte with bit 6
// set restarts the packet. The event appears in the output register in the
// cycle after the byte that completes it; the input stays ready while that
// register is empty or being drained, so with a drained output the single
// output register sustains one byte per cycle. Down and up flags report
// each button that changed against the previous event.
module serial_mouse_packet_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [smpd_pkg::RX_W-1:0]     s_tdata,  // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] delta_x, [15:8] delta_y, [16] left_pressed, [17] right_pressed,
    // [18] middle_pressed, [19] left_went_down, [20] left_went_up,
    // [21] right_went_down, [22] right_went_up, [23] middle_went_down,
    // [24] middle_went_up, [31:25] zero
    output logic [smpd_pkg::TDATA_W-1:0]  m_tdata
);
    import smpd_pkg::*;

    pos_t               pos_reg;
    logic [BTN_W-1:0]   buttons_reg;
    logic [DATA_W-1:0]  byte0_reg;
    logic [DATA_W-1:0]  byte1_reg;
    logic               m_valid_reg;
    result_t            result_reg;
    decode_t            dec;
    logic               accept;

    smpd_decode u_decode (
        .rx_byte (s_tdata),
        .pos     (pos_reg),
        .byte0   (byte0_reg),
        .byte1   (byte1_reg),
        .buttons (buttons_reg),
        .dec     (dec)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_BYTE0;
            buttons_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg     <= dec.pos_next;
                buttons_reg <= dec.buttons_next;
                m_valid_reg <= dec.emit;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && dec.wr_byte0)
        begin
            byte0_reg <= s_tdata[DATA_W-1:0];
        end
        if (accept && dec.wr_byte1)
        begin
            byte1_reg <= s_tdata[DATA_W-1:0];
        end
        if (accept && dec.emit)
        begin
            result_reg <= dec.result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, result_reg};

endmodule

[rtl/smpd_checker.sv]
// ----------------------------------------------------------------------------
// smpd_checker
// port-level checks for the serial mouse packet decoder
// ----------------------------------------------------------------------------
module smpd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [smpd_pkg::TDATA_W-1:0]  m_tdata
);
    import smpd_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    // input never blocked while output is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // flags agree with current button state
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[19] || m_tdata[16]) && (!m_tdata[20] || !m_tdata[16])
                  && (!m_tdata[21] || m_tdata[17]) && (!m_tdata[22] || !m_tdata[17])
                  && (!m_tdata[23] || m_tdata[18]) && (!m_tdata[24] || !m_tdata[18]))
        else $error("button flag disagrees with state");

    // middle change events carry no motion
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[23] || m_tdata[24]) |-> m_tdata[15:0] == '0)
        else $error("middle event with motion");

    // no output word appears without an accepted input byte
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) && m_tready |=> !m_tvalid)
        else $error("output word without input byte");

endmodule

bind serial_mouse_packet_decoder smpd_checker u_smpd_checker (.*);

[tb/serial_mouse_packet_decoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder_tb
// self-checking bench for the serial mouse packet decoder
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes covers all-zero and full-scale motion,
// start marks with bit 7 set, restarts in the middle of a packet, fourth
// bytes that toggle or keep the middle button and unmarked bytes after a
// fourth byte. Random traffic follows, mostly well-formed packets with and
// without a fourth byte, mixed with cut-short packets and raw noise. Each
// accepted byte runs through a behavioral decoder kept in the bench, and
// every output word is compared with the oldest predicted event. Both sides
// of the stream stall at random in all but the last random phase.
module serial_mouse_packet_decoder_tb;

    import smpd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {
        ROW_QUIET,
        ROW_EVENT,
        ROW_PRED
    } row_kind_t;

    typedef struct packed {
        logic [RX_W-1:0]    rx;
        row_kind_t          kind;
        logic [TDATA_W-1:0] word;
    } stim_row_t;

    localparam int NUM_ROWS = 26;

    localparam stim_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        '{8'h40, ROW_QUIET, 32'h0000_0000},
        '{8'h00, ROW_QUIET, 32'h0000_0000},
        '{8'h00, ROW_EVENT, 32'h0000_0000},
        '{8'h7f, ROW_QUIET, 32'h0000_0000},
        '{8'h3f, ROW_QUIET, 32'h0000_0000},
        '{8'h3f, ROW_EVENT, 32'h002b_ffff},
        '{8'ha0, ROW_EVENT, 32'h0087_0000},
        '{8'hc0, ROW_PRED,  32'h0000_0000},
        '{8'h80, ROW_PRED,  32'h0000_0000},
        '{8'hff, ROW_PRED,  32'h0000_0000},
        '{8'h9f, ROW_PRED,  32'h0000_0000},
        '{8'h20, ROW_PRED,  32'h0000_0000},
        '{8'h00, ROW_EVENT, 32'h0103_0000},
        '{8'h05, ROW_PRED,  32'h0000_0000},
        '{8'h00, ROW_PRED,  32'h0000_0000},
        '{8'h01, ROW_PRED,  32'h0000_0000},
        '{8'h3f, ROW_PRED,  32'h0000_0000},
        '{8'h70, ROW_PRED,  32'h0000_0000},
        '{8'h01, ROW_PRED,  32'h0000_0000},
        '{8'h40, ROW_PRED,  32'h0000_0000},
        '{8'h02, ROW_PRED,  32'h0000_0000},
        '{8'h03, ROW_PRED,  32'h0000_0000},
        '{8'h20, ROW_QUIET, 32'h0000_0000},
        '{8'h4a, ROW_PRED,  32'h0000_0000},
        '{8'h00, ROW_PRED,  32'h0000_0000},
        '{8'h00, ROW_PRED,  32'h0000_0000}
    };

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [RX_W-1:0]    s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    // behavioral decoder state
    logic [2:0]         mouse_pos;
    logic [DATA_W-1:0]  mouse_bytes [0:2];
    logic [BTN_W-1:0]   mouse_buttons;

    logic [TDATA_W-1:0] pending_events [$];
    logic [TDATA_W-1:0] exp_word;

    int                 src_idle_pct = 37;
    int                 snk_idle_pct = 88;
    int                 fail_count   = 0;
    int                 mismatches   = 0;
    int                 cycles       = 0;

    serial_mouse_packet_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    // builds an event word and moves the held buttons to the new state
    function automatic result_t button_event(input logic [7:0] dx, input logic [7:0] dy,
                                             input logic [BTN_W-1:0] now);
        result_t          ev;
        logic [BTN_W-1:0] diff;
        diff                = mouse_buttons ^ now;
        ev.delta_x          = dx;
        ev.delta_y          = dy;
        ev.left_pressed     = now[BTN_LEFT];
        ev.right_pressed    = now[BTN_RIGHT];
        ev.middle_pressed   = now[BTN_MIDDLE];
        ev.left_went_down   = diff[BTN_LEFT] & now[BTN_LEFT];
        ev.left_went_up     = diff[BTN_LEFT] & ~now[BTN_LEFT];
        ev.right_went_down  = diff[BTN_RIGHT] & now[BTN_RIGHT];
        ev.right_went_up    = diff[BTN_RIGHT] & ~now[BTN_RIGHT];
        ev.middle_went_down = diff[BTN_MIDDLE] & now[BTN_MIDDLE];
        ev.middle_went_up   = diff[BTN_MIDDLE] & ~now[BTN_MIDDLE];
        mouse_buttons       = now;
        return ev;
    endfunction

    // returns 1 when the byte completes an event
    function automatic bit decode_byte(input logic [RX_W-1:0] rx, output result_t ev);
        logic [DATA_W-1:0] data;
        logic [2:0]        pos;
        logic [7:0]        dx;
        logic [7:0]        dy;
        logic [BTN_W-1:0]  now;
        data = rx[DATA_W-1:0];
        pos  = rx[START_BIT] ? 3'd0 : mouse_pos;
        ev   = '0;
        if (pos < 3'd3)
        begin
            mouse_bytes[pos[1:0]] = data;
            mouse_pos             = pos + 3'd1;
            if (mouse_pos != 3'd3)
                return 1'b0;
            dx  = {1'b0, mouse_bytes[1]} | {mouse_bytes[0][1:0], 6'b0};
            dy  = {1'b0, mouse_bytes[2]} | {mouse_bytes[0][3:2], 6'b0};
            now = {mouse_buttons[BTN_MIDDLE], mouse_bytes[0][4], mouse_bytes[0][5]};
            ev  = button_event(dx, dy, now);
            return 1'b1;
        end
        mouse_pos = 3'd0;
        if (data[MIDDLE_BIT] == mouse_buttons[BTN_MIDDLE])
            return 1'b0;
        now       = mouse_buttons;
        now[BTN_MIDDLE] = ~now[BTN_MIDDLE];
        ev        = button_event(8'h00, 8'h00, now);
        return 1'b1;
    endfunction

    // hands one byte to the block and returns once it is taken
    task automatic push_byte(input logic [RX_W-1:0] rx, input row_kind_t kind,
                             input logic [TDATA_W-1:0] word);
        result_t ev;
        bit      has_ev;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        has_ev = decode_byte(rx, ev);
        if (kind == ROW_EVENT)
            pending_events.push_back(word);
        else if (kind == ROW_PRED && has_ev)
            pending_events.push_back({{PAD_W{1'b0}}, ev});
    endtask

    task automatic send_random(input int n_bytes);
        int              sent;
        int              pick;
        int              n_payload;
        logic [RX_W-1:0] rx;
        sent = 0;
        while (sent < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 88)
            begin
                // well-formed packets, or cut short
                if (pick < 75)
                    n_payload = 2 + $urandom_range(1);
                else
                    n_payload = $urandom_range(1);
                rx            = RX_W'($urandom);
                rx[START_BIT] = 1'b1;
                push_byte(rx, ROW_PRED, '0);
                repeat (n_payload)
                begin
                    rx            = RX_W'($urandom);
                    rx[START_BIT] = 1'b0;
                    push_byte(rx, ROW_PRED, '0);
                end
                sent += 1 + n_payload;
            end
            else
            begin
                rx = RX_W'($urandom);
                push_byte(rx, ROW_PRED, '0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected word %h", m_tdata);
                mismatches++;
                fail_count++;
            end
            else
            begin
                exp_word = pending_events.pop_front();
                if (m_tdata !== exp_word)
                begin
                    if (mismatches < 10)
                        $display("word mismatch: dx %h/%h dy %h/%h flags %b/%b (exp/act)",
                                 exp_word[7:0], m_tdata[7:0], exp_word[15:8], m_tdata[15:8],
                                 exp_word[31:16], m_tdata[31:16]);
                    mismatches++;
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        mouse_pos      = 3'd0;
        mouse_bytes[0] = '0;
        mouse_bytes[1] = '0;
        mouse_bytes[2] = '0;
        mouse_buttons  = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            push_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].word);

        send_random(525);
        src_idle_pct = 88;
        snk_idle_pct = 37;
        send_random(525);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_random(525);

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
